[rtl/rbwf_pkg.sv]
`default_nettype none

package rbwf_pkg;

	// Fixed field widths of the pixel, result and configuration channels.
	localparam int FUNC_W   = 1;
	localparam int TIDX_W   = 10;
	localparam int TVAL_W   = 17;
	localparam int CHAN8_W  = 8;
	localparam int COLOR_W  = 24;
	localparam int SIG_W    = 32;
	localparam int GAIN_W   = 17;
	localparam int CUSED_W  = 2;
	localparam int CIDX_W   = 1;
	localparam int CDATA_W  = 17;

	// Weight table holds one entry per summed colour distance.
	localparam int TAB_DEPTH = 769;

	// Q16.16 one and the rounding offset for a 16-bit right shift.
	localparam logic [GAIN_W-1:0] ONE_Q16   = 17'd65536;
	localparam int                HALF_Q16  = 32768;

	// Register reset values.
	localparam logic [GAIN_W-1:0]  GAIN_RESET  = 17'd52429;
	localparam logic [CUSED_W-1:0] CUSED_RESET = 2'd3;

	// Register indexes of the configuration port.
	localparam logic [CIDX_W-1:0] REG_SPREAD_GAIN   = 1'b0;
	localparam logic [CIDX_W-1:0] REG_CHANNELS_USED = 1'b1;

	// Request function codes.
	localparam logic [FUNC_W-1:0] FUNC_TABLE = 1'b0;
	localparam logic [FUNC_W-1:0] FUNC_PIXEL = 1'b1;

	// Bit-serial divider: 49-bit numerator, one quotient bit per cycle.
	localparam int DIV_STEPS = 49;
	localparam int DIV_CW    = 6;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_pix;
		logic load_tab;
		logic rd0;
		logic rd1;
		logic lookup;
		logic gk;
		logic mul;
		logic add;
		logic drd;
		logic dload;
		logic diter;
		logic dout;
		logic pass2;
		logic bwd;
		logic first;
		logic last;
	} rbwf_cmd_t;

endpackage

`default_nettype wire

[rtl/rbwf_if.sv]
`default_nettype none

// Pixel and weight table request channel.
interface rbwf_pixel_if;
	logic                             valid;
	logic                             ready;
	logic [rbwf_pkg::FUNC_W-1:0]      func;
	logic [rbwf_pkg::TIDX_W-1:0]      table_index;
	logic [rbwf_pkg::TVAL_W-1:0]      table_value;
	logic [rbwf_pkg::CHAN8_W-1:0]     color_0;
	logic [rbwf_pkg::CHAN8_W-1:0]     color_1;
	logic [rbwf_pkg::CHAN8_W-1:0]     color_2;
	logic [rbwf_pkg::SIG_W-1:0]       signal_in;
	logic                             last_pixel;

	modport source (output valid, func, table_index, table_value, color_0, color_1, color_2,
		signal_in, last_pixel, input ready);
	modport sink (input valid, func, table_index, table_value, color_0, color_1, color_2,
		signal_in, last_pixel, output ready);
endinterface

// Filtered result channel.
interface rbwf_result_if;
	logic                       valid;
	logic                       ready;
	logic [rbwf_pkg::SIG_W-1:0] filtered_out;
	logic                       last_out;

	modport source (output valid, filtered_out, last_out, input ready);
	modport sink (input valid, filtered_out, last_out, output ready);
endinterface

// Register write channel.
interface rbwf_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [rbwf_pkg::CIDX_W-1:0]  index;
	logic [rbwf_pkg::CDATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/recursive_bilateral_window_filter.sv]
// Loading: one request per cycle while idle; weight table and pixel requests are taken at once.
// Filtering starts on the last pixel: four sweeps of SIDE*SIDE element steps, each a read,
// neighbor color, distance lookup, coefficient, multiply and add; then per element a
// bit-serial divide, whose result waits while the previous result is still held.
// Reset clears the sequencer, load count, output valid and both registers to their defaults;
// window stores and the weight table hold no reset value and need no clearing pass.
`default_nettype none

module recursive_bilateral_window_filter #(
	parameter int SIDE     = 7,
	parameter int CHANNELS = 3
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	rbwf_pixel_if.sink  pixel,
	rbwf_result_if.source result,
	rbwf_cfg_if.sink    cfg
);

	localparam int AW = $clog2(SIDE * SIDE);
	localparam int PW = $clog2(SIDE);

	rbwf_pkg::rbwf_cmd_t cmd;
	logic [AW-1:0]       addr, nbr, load_addr;
	logic [PW-1:0]       pos;
	logic                out_busy;

	// Registers are always writable.
	assign cfg.ready = 1'b1;

	rbwf_ctrl #(.SIDE(SIDE)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pixel.valid),
		.in_func   (pixel.func),
		.in_last   (pixel.last_pixel),
		.in_ready  (pixel.ready),
		.out_busy  (out_busy),
		.cmd       (cmd),
		.addr      (addr),
		.nbr       (nbr),
		.pos       (pos),
		.load_addr (load_addr)
	);

	rbwf_datapath #(.SIDE(SIDE), .CHANNELS(CHANNELS)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.addr        (addr),
		.nbr         (nbr),
		.pos         (pos),
		.load_addr   (load_addr),
		.table_index (pixel.table_index),
		.table_value (pixel.table_value),
		.color_0     (pixel.color_0),
		.color_1     (pixel.color_1),
		.color_2     (pixel.color_2),
		.signal_in   (pixel.signal_in),
		.cfg_we      (cfg.valid),
		.cfg_index   (cfg.index),
		.cfg_data    (cfg.data),
		.out_ready   (result.ready),
		.out_valid   (result.valid),
		.out_data    (result.filtered_out),
		.out_last    (result.last_out),
		.out_busy    (out_busy)
	);

endmodule

`default_nettype wire

[rtl/rbwf_ram.sv]
`default_nettype none

module rbwf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 49
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

[rtl/rbwf_datapath.sv]
`default_nettype none

module rbwf_datapath #(
	parameter int SIDE     = 7,
	parameter int CHANNELS = 3
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire rbwf_pkg::rbwf_cmd_t                 cmd,
	input  wire logic [$clog2(SIDE*SIDE)-1:0]        addr,
	input  wire logic [$clog2(SIDE*SIDE)-1:0]        nbr,
	input  wire logic [$clog2(SIDE)-1:0]             pos,
	input  wire logic [$clog2(SIDE*SIDE)-1:0]        load_addr,
	input  wire logic [rbwf_pkg::TIDX_W-1:0]         table_index,
	input  wire logic [rbwf_pkg::TVAL_W-1:0]         table_value,
	input  wire logic [rbwf_pkg::CHAN8_W-1:0]        color_0,
	input  wire logic [rbwf_pkg::CHAN8_W-1:0]        color_1,
	input  wire logic [rbwf_pkg::CHAN8_W-1:0]        color_2,
	input  wire logic [rbwf_pkg::SIG_W-1:0]          signal_in,
	input  wire logic                                cfg_we,
	input  wire logic [rbwf_pkg::CIDX_W-1:0]         cfg_index,
	input  wire logic [rbwf_pkg::CDATA_W-1:0]        cfg_data,
	input  wire logic                                out_ready,
	output logic                                     out_valid,
	output logic      [rbwf_pkg::SIG_W-1:0]          out_data,
	output logic                                     out_last,
	output logic                                     out_busy
);

	localparam int WIN  = SIDE * SIDE;
	localparam int AW   = $clog2(WIN);
	localparam int TAW  = $clog2(rbwf_pkg::TAB_DEPTH);
	localparam int DW   = rbwf_pkg::DIV_STEPS;
	localparam int SW   = rbwf_pkg::SIG_W;
	localparam int KW   = rbwf_pkg::GAIN_W;
	localparam logic [SW-1:0] SAT = '1;

	// Configuration registers.
	logic [rbwf_pkg::GAIN_W-1:0]  gain_q;
	logic [rbwf_pkg::CUSED_W-1:0] chan_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= rbwf_pkg::GAIN_RESET;
			chan_q <= rbwf_pkg::CUSED_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rbwf_pkg::REG_SPREAD_GAIN:   gain_q <= cfg_data;
				rbwf_pkg::REG_CHANNELS_USED: chan_q <= cfg_data[rbwf_pkg::CUSED_W-1:0];
				default: ;
			endcase
		end
	end

	// Memory read data.
	logic [rbwf_pkg::COLOR_W-1:0] col_rd;
	logic [SW-1:0]                sig_rd, pas_rd, wgt_rd, wsum_rd;
	logic [rbwf_pkg::TVAL_W-1:0]  tab_rd;

	// Working registers of the recursion.
	logic [SW-1:0]                x_q, xw_q, mt_q, mw_q, t_q, w_q;
	logic [rbwf_pkg::COLOR_W-1:0] ca_q;
	logic [KW-1:0]                k_q;
	logic [SW-1:0]                ft_q [SIDE];
	logic [SW-1:0]                fw_q [SIDE];

	// Divider and output registers.
	logic [DW-1:0] num_q;
	logic [SW-1:0] rem_q, den_q;
	logic          out_valid_q, out_last_q;
	logic [SW-1:0] out_data_q;

	// Colour distance over the active channels.
	logic [1:0]          ch;
	logic [7:0]          d0, d1, d2;
	logic [TAW-1:0]      cdist;

	function automatic logic [7:0] absdiff(input logic [7:0] a, input logic [7:0] b);
		return (a > b) ? a - b : b - a;
	endfunction

	always_comb begin
		if (chan_q == 2'd0) begin
			ch = 2'd1;
		end else if (chan_q > 2'(CHANNELS)) begin
			ch = 2'(CHANNELS);
		end else begin
			ch = chan_q;
		end
		d0 = absdiff(ca_q[7:0], col_rd[7:0]);
		d1 = (ch >= 2'd2) ? absdiff(ca_q[15:8], col_rd[15:8]) : 8'd0;
		d2 = (ch == 2'd3) ? absdiff(ca_q[23:16], col_rd[23:16]) : 8'd0;
		cdist = TAW'(d0) + TAW'(d1) + TAW'(d2);
	end

	// Edge coefficient from the clamped gain and table weight.
	logic [KW-1:0]     g_cl, w_cl;
	logic [2*KW-1:0]   kprod;

	always_comb begin
		g_cl  = (gain_q > rbwf_pkg::ONE_Q16) ? rbwf_pkg::ONE_Q16 : gain_q;
		w_cl  = (tab_rd > rbwf_pkg::ONE_Q16) ? rbwf_pkg::ONE_Q16 : tab_rd;
		kprod = (2*KW)'(g_cl) * (2*KW)'(w_cl) + (2*KW)'(rbwf_pkg::HALF_Q16);
	end

	// Scaled carries of the recursion, rounded and saturated.
	logic [SW+KW-1:0] pt, pw;

	always_comb begin
		pt = (SW+KW)'(t_q) * (SW+KW)'(k_q) + (SW+KW)'(rbwf_pkg::HALF_Q16);
		pw = (SW+KW)'(w_q) * (SW+KW)'(k_q) + (SW+KW)'(rbwf_pkg::HALF_Q16);
	end

	// Recursion step and the two-direction merge.
	logic [SW:0]   st, sw, mt2, mw2;
	logic [SW-1:0] tn, wn, tsum, wsum, yt, yw;

	always_comb begin
		st   = {1'b0, x_q} + {1'b0, mt_q};
		sw   = {1'b0, xw_q} + {1'b0, mw_q};
		tn   = cmd.first ? x_q : (st[SW] ? SAT : st[SW-1:0]);
		wn   = cmd.first ? xw_q : (sw[SW] ? SAT : sw[SW-1:0]);
		mt2  = {1'b0, ft_q[pos]} + {1'b0, tn};
		mw2  = {1'b0, fw_q[pos]} + {1'b0, wn};
		tsum = mt2[SW] ? SAT : mt2[SW-1:0];
		wsum = mw2[SW] ? SAT : mw2[SW-1:0];
		yt   = (tsum > x_q) ? tsum - x_q : '0;
		yw   = (wsum > xw_q) ? wsum - xw_q : '0;
	end

	// One restoring division step, and the saturated quotient.
	logic [SW:0]   rem_sh;
	logic          ge;
	logic [SW:0]   rem_sub;
	logic [SW-1:0] qres;

	always_comb begin
		rem_sh  = {rem_q, num_q[DW-1]};
		ge      = rem_sh >= {1'b0, den_q};
		rem_sub = rem_sh - {1'b0, den_q};
		if (den_q == '0 || num_q[DW-1:SW] != '0) begin
			qres = SAT;
		end else begin
			qres = num_q[SW-1:0];
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (cmd.rd1) begin
			x_q  <= cmd.pass2 ? pas_rd : sig_rd;
			xw_q <= cmd.pass2 ? wgt_rd : SW'(rbwf_pkg::ONE_Q16);
			ca_q <= col_rd;
		end
		if (cmd.gk) begin
			k_q <= kprod[KW+15:16];
		end
		if (cmd.mul) begin
			mt_q <= pt[SW+KW-1] ? SAT : pt[SW+15:16];
			mw_q <= pw[SW+KW-1] ? SAT : pw[SW+15:16];
		end
		if (cmd.add) begin
			t_q <= tn;
			w_q <= wn;
			if (!cmd.bwd) begin
				ft_q[pos] <= tn;
				fw_q[pos] <= wn;
			end
		end
		if (cmd.dload) begin
			num_q <= DW'({sig_rd, 16'd0}) + DW'(wsum_rd >> 1);
			rem_q <= '0;
			den_q <= wsum_rd;
		end else if (cmd.diter) begin
			num_q <= {num_q[DW-2:0], ge};
			rem_q <= ge ? rem_sub[SW-1:0] : rem_sh[SW-1:0];
		end
		if (cmd.dout) begin
			out_data_q <= qres;
			out_last_q <= cmd.last;
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.dout) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_last  = out_last_q;
	assign out_busy  = out_valid_q;

	// Window stores.
	logic            sig_we;
	logic [AW-1:0]   sig_wa;
	logic [SW-1:0]   sig_wd;
	logic            tab_we;

	always_comb begin
		sig_we = cmd.load_pix || (cmd.add && cmd.bwd && cmd.pass2) || cmd.dout;
		sig_wa = cmd.load_pix ? load_addr : addr;
		if (cmd.load_pix) begin
			sig_wd = signal_in;
		end else if (cmd.dout) begin
			sig_wd = qres;
		end else begin
			sig_wd = yt;
		end
		tab_we = cmd.load_tab && (table_index < TAW'(rbwf_pkg::TAB_DEPTH));
	end

	rbwf_ram #(.WIDTH(rbwf_pkg::COLOR_W), .DEPTH(WIN)) u_col (
		.clk(clk), .we(cmd.load_pix), .waddr(load_addr),
		.wdata({color_2, color_1, color_0}),
		.raddr(cmd.rd1 ? nbr : addr), .rdata(col_rd)
	);

	rbwf_ram #(.WIDTH(SW), .DEPTH(WIN)) u_sig (
		.clk(clk), .we(sig_we), .waddr(sig_wa), .wdata(sig_wd),
		.raddr(addr), .rdata(sig_rd)
	);

	rbwf_ram #(.WIDTH(SW), .DEPTH(WIN)) u_pas (
		.clk(clk), .we(cmd.add && cmd.bwd && !cmd.pass2), .waddr(addr), .wdata(yt),
		.raddr(addr), .rdata(pas_rd)
	);

	rbwf_ram #(.WIDTH(SW), .DEPTH(WIN)) u_wgt (
		.clk(clk), .we(cmd.add && cmd.bwd && !cmd.pass2), .waddr(addr), .wdata(yw),
		.raddr(addr), .rdata(wgt_rd)
	);

	rbwf_ram #(.WIDTH(SW), .DEPTH(WIN)) u_wsum (
		.clk(clk), .we(cmd.add && cmd.bwd && cmd.pass2), .waddr(addr), .wdata(yw),
		.raddr(addr), .rdata(wsum_rd)
	);

	rbwf_ram #(.WIDTH(rbwf_pkg::TVAL_W), .DEPTH(rbwf_pkg::TAB_DEPTH)) u_tab (
		.clk(clk), .we(tab_we), .waddr(table_index), .wdata(table_value),
		.raddr(cdist), .rdata(tab_rd)
	);

endmodule

`default_nettype wire

[rtl/rbwf_ctrl.sv]
`default_nettype none

module rbwf_ctrl #(
	parameter int SIDE = 7
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	input  wire logic [rbwf_pkg::FUNC_W-1:0]   in_func,
	input  wire logic                          in_last,
	output logic                               in_ready,
	input  wire logic                          out_busy,
	output rbwf_pkg::rbwf_cmd_t                cmd,
	output logic      [$clog2(SIDE*SIDE)-1:0]  addr,
	output logic      [$clog2(SIDE*SIDE)-1:0]  nbr,
	output logic      [$clog2(SIDE)-1:0]       pos,
	output logic      [$clog2(SIDE*SIDE)-1:0]  load_addr
);

	localparam int WIN = SIDE * SIDE;
	localparam int AW  = $clog2(WIN);
	localparam int PW  = $clog2(SIDE);
	localparam int CW  = $clog2(WIN + 1);

	localparam logic [PW-1:0] POS_LAST  = PW'(SIDE - 1);
	localparam logic [AW-1:0] WIN_LAST  = AW'(WIN - 1);
	localparam logic [AW-1:0] SIDE_A    = AW'(SIDE);
	localparam logic [CW-1:0] LOAD_FULL = CW'(WIN);
	localparam logic [rbwf_pkg::DIV_CW-1:0] BIT_LAST = rbwf_pkg::DIV_CW'(rbwf_pkg::DIV_STEPS - 1);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_RD0   = 4'd1;
	localparam logic [3:0] S_RD1   = 4'd2;
	localparam logic [3:0] S_DIST  = 4'd3;
	localparam logic [3:0] S_GK    = 4'd4;
	localparam logic [3:0] S_MUL   = 4'd5;
	localparam logic [3:0] S_ADD   = 4'd6;
	localparam logic [3:0] S_DRD   = 4'd7;
	localparam logic [3:0] S_DLOAD = 4'd8;
	localparam logic [3:0] S_DITER = 4'd9;
	localparam logic [3:0] S_DWAIT = 4'd10;
	localparam logic [3:0] S_DOUT  = 4'd11;

	logic [3:0]                   state_q;
	logic                         pass2_q, bwd_q;
	logic [PW-1:0]                line_q, pos_q;
	logic [AW-1:0]                elem_q;
	logic [rbwf_pkg::DIV_CW-1:0]  bit_q;
	logic [CW-1:0]                load_q;

	logic accept, first;
	logic [AW-1:0] idx, step, line_a, pos_a;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_ready && in_valid;

	// Element index of the current sweep position and its recursion neighbor.
	always_comb begin
		line_a = AW'(line_q);
		pos_a  = AW'(pos_q);
		if (pass2_q) begin
			idx  = AW'(line_a * SIDE_A + pos_a);
			step = AW'(1);
		end else begin
			idx  = AW'(line_a + pos_a * SIDE_A);
			step = SIDE_A;
		end
		first = bwd_q ? (pos_q == POS_LAST) : (pos_q == '0);
		if (first) begin
			nbr = idx;
		end else if (bwd_q) begin
			nbr = idx + step;
		end else begin
			nbr = idx - step;
		end
		if (state_q == S_DRD || state_q == S_DLOAD || state_q == S_DITER ||
			state_q == S_DWAIT || state_q == S_DOUT) begin
			addr = elem_q;
		end else begin
			addr = idx;
		end
	end

	assign pos       = pos_q;
	assign load_addr = load_q[AW-1:0];

	// Command decode.
	always_comb begin
		cmd          = '0;
		cmd.load_pix = accept && (in_func == rbwf_pkg::FUNC_PIXEL) && (load_q < LOAD_FULL);
		cmd.load_tab = accept && (in_func == rbwf_pkg::FUNC_TABLE);
		cmd.rd0      = (state_q == S_RD0);
		cmd.rd1      = (state_q == S_RD1);
		cmd.lookup   = (state_q == S_DIST);
		cmd.gk       = (state_q == S_GK);
		cmd.mul      = (state_q == S_MUL);
		cmd.add      = (state_q == S_ADD);
		cmd.drd      = (state_q == S_DRD);
		cmd.dload    = (state_q == S_DLOAD);
		cmd.diter    = (state_q == S_DITER);
		cmd.dout     = (state_q == S_DOUT);
		cmd.pass2    = pass2_q;
		cmd.bwd      = bwd_q;
		cmd.first    = first;
		cmd.last     = (elem_q == WIN_LAST);
	end

	// Sequencer: load, four sweeps of element steps, then divide and emit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pass2_q <= 1'b0;
			bwd_q   <= 1'b0;
			line_q  <= '0;
			pos_q   <= '0;
			elem_q  <= '0;
			bit_q   <= '0;
			load_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd.load_pix) begin
						load_q <= load_q + CW'(1);
					end
					if (accept && in_func == rbwf_pkg::FUNC_PIXEL && in_last) begin
						load_q  <= '0;
						pass2_q <= 1'b0;
						bwd_q   <= 1'b0;
						line_q  <= '0;
						pos_q   <= '0;
						state_q <= S_RD0;
					end
				end
				S_RD0:  state_q <= S_RD1;
				S_RD1:  state_q <= S_DIST;
				S_DIST: state_q <= S_GK;
				S_GK:   state_q <= S_MUL;
				S_MUL:  state_q <= S_ADD;
				S_ADD: begin
					state_q <= S_RD0;
					if (!bwd_q) begin
						if (pos_q == POS_LAST) begin
							bwd_q <= 1'b1;
						end else begin
							pos_q <= pos_q + PW'(1);
						end
					end else if (pos_q != '0) begin
						pos_q <= pos_q - PW'(1);
					end else begin
						bwd_q <= 1'b0;
						if (line_q != POS_LAST) begin
							line_q <= line_q + PW'(1);
						end else begin
							line_q <= '0;
							if (!pass2_q) begin
								pass2_q <= 1'b1;
							end else begin
								elem_q  <= '0;
								state_q <= S_DRD;
							end
						end
					end
				end
				S_DRD:   state_q <= S_DLOAD;
				S_DLOAD: begin
					bit_q   <= '0;
					state_q <= S_DITER;
				end
				S_DITER: begin
					bit_q <= bit_q + rbwf_pkg::DIV_CW'(1);
					if (bit_q == BIT_LAST) begin
						state_q <= S_DWAIT;
					end
				end
				S_DWAIT: begin
					if (!out_busy) begin
						state_q <= S_DOUT;
					end
				end
				S_DOUT: begin
					if (elem_q == WIN_LAST) begin
						state_q <= S_IDLE;
					end else begin
						elem_q  <= elem_q + AW'(1);
						state_q <= S_DRD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

[rtl/rbwf_checker.sv]
`default_nettype none

module rbwf_props (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          in_valid,
	input wire logic                          in_ready,
	input wire logic [rbwf_pkg::FUNC_W-1:0]   in_func,
	input wire logic                          in_last,
	input wire logic                          out_valid,
	input wire logic                          out_ready,
	input wire logic [rbwf_pkg::SIG_W-1:0]    out_data,
	input wire logic                          out_last
);

	// A stalled result holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data) && $stable(out_last))
		else $error("result changed while stalled");

	// No request is taken while a window is still being emitted.
	a_busy_emit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_last |-> !in_ready)
		else $error("request taken during window output");

	// A window's last pixel starts filtering, which blocks further requests.
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_func == rbwf_pkg::FUNC_PIXEL && in_last |=> !in_ready)
		else $error("filter did not start on last pixel");

	// A table write never produces a result.
	a_table_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_func == rbwf_pkg::FUNC_TABLE && !out_valid |=> !out_valid)
		else $error("table write produced a result");

endmodule

bind recursive_bilateral_window_filter rbwf_props u_rbwf_props (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (pixel.valid),
	.in_ready  (pixel.ready),
	.in_func   (pixel.func),
	.in_last   (pixel.last_pixel),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_data  (result.filtered_out),
	.out_last  (result.last_out)
);

`default_nettype wire

[dv/rbwf_tb_if_note.sv]
`default_nettype none

// Shared sizes for the window filter testbench.
package rbwf_tb_pkg;
	localparam int SIDE   = 7;
	localparam int WIN    = SIDE * SIDE;
	localparam int MAXCH  = 3;
endpackage

`default_nettype wire

[dv/rbwf_checker.sv]
`default_nettype none

module rbwf_checker (
	input wire logic clk,
	input wire logic arst_n,
	rbwf_pixel_if.sink  pixel,
	rbwf_result_if.sink result,
	rbwf_cfg_if.sink    cfg,
	output int          fail_count,
	output int          pending
);
	import rbwf_pkg::*;
	import rbwf_tb_pkg::*;

	typedef struct packed {
		logic [SIG_W-1:0] value;
		logic             last;
	} filt_t;

	// Predictor state.
	logic [GAIN_W-1:0]  gain;
	logic [CUSED_W-1:0] cused;
	logic [23:0]        colors [WIN];
	logic [31:0]        sigs   [WIN];
	logic [16:0]        wtab   [TAB_DEPTH];
	int                 loaded;
	filt_t              awaited [$];

	assign pending = awaited.size();

	function automatic logic [31:0] sat(logic [63:0] v);
		return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
	endfunction

	function automatic logic [31:0] scale(logic [31:0] v, logic [31:0] k);
		logic [63:0] p;
		p = (64'(v) * 64'(k) + 64'd32768) >> 16;
		return sat(p);
	endfunction

	function automatic logic [31:0] coef(int a, int b);
		int ch, d, pa, pb;
		logic [31:0] w, g;
		logic [63:0] p;
		ch = (cused == 0) ? 1 : ((cused > MAXCH) ? MAXCH : int'(cused));
		d = 0;
		for (int c = 0; c < ch; c++) begin
			pa = int'(colors[a][8*c +: 8]);
			pb = int'(colors[b][8*c +: 8]);
			d += (pa > pb) ? pa - pb : pb - pa;
		end
		w = 32'(wtab[d]);
		if (w > 32'd65536) w = 32'd65536;
		g = (gain > ONE_Q16) ? 32'd65536 : 32'(gain);
		p = (64'(g) * 64'(w) + 64'd32768) >> 16;
		return p[31:0];
	endfunction

	// One forward plus backward line recursion, minus the twice-counted input.
	task automatic line_pass(input int base, input int stride,
			input logic [31:0] xs [WIN], input logic [31:0] xw [WIN],
			inout logic [31:0] ys [WIN], inout logic [31:0] yw [WIN]);
		logic [31:0] ft [SIDE];
		logic [31:0] fw [SIDE];
		logic [31:0] t, w, k, a, b;
		int idx;
		t = 0;
		w = 0;
		for (int i = 0; i < SIDE; i++) begin
			idx = base + i * stride;
			if (i == 0) begin
				t = xs[idx];
				w = xw[idx];
			end else begin
				k = coef(idx, idx - stride);
				t = sat(64'(xs[idx]) + 64'(scale(t, k)));
				w = sat(64'(xw[idx]) + 64'(scale(w, k)));
			end
			ft[i] = t;
			fw[i] = w;
		end
		for (int i = SIDE - 1; i >= 0; i--) begin
			idx = base + i * stride;
			if (i == SIDE - 1) begin
				t = xs[idx];
				w = xw[idx];
			end else begin
				k = coef(idx, idx + stride);
				t = sat(64'(xs[idx]) + 64'(scale(t, k)));
				w = sat(64'(xw[idx]) + 64'(scale(w, k)));
			end
			a = sat(64'(ft[i]) + 64'(t));
			b = sat(64'(fw[i]) + 64'(w));
			ys[idx] = (a > xs[idx]) ? a - xs[idx] : 0;
			yw[idx] = (b > xw[idx]) ? b - xw[idx] : 0;
		end
	endtask

	// Filter the whole window and queue every normalized value.
	task automatic filter_window();
		logic [31:0] ones [WIN];
		logic [31:0] p1 [WIN];
		logic [31:0] w1 [WIN];
		logic [31:0] p2 [WIN];
		logic [31:0] w2 [WIN];
		logic [63:0] num;
		filt_t r;
		for (int i = 0; i < WIN; i++) ones[i] = 32'd65536;
		for (int j = 0; j < SIDE; j++) line_pass(j, SIDE, sigs, ones, p1, w1);
		for (int j = 0; j < SIDE; j++) line_pass(j * SIDE, 1, p1, w1, p2, w2);
		for (int i = 0; i < WIN; i++) begin
			if (w2[i] == 0) r.value = 32'hFFFF_FFFF;
			else begin
				num = ((64'(p2[i]) << 16) + 64'(w2[i] >> 1)) / 64'(w2[i]);
				r.value = sat(num);
			end
			r.last = (i == WIN - 1);
			sigs[i] = r.value;
			awaited.push_back(r);
		end
		loaded = 0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		filt_t e;
		int errs;
		if (!arst_n) begin
			gain <= GAIN_RESET;
			cused <= CUSED_RESET;
			loaded = 0;
			awaited.delete();
			fail_count <= 0;
		end else begin
			errs = 0;
			// Register writes.
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == REG_SPREAD_GAIN) gain <= cfg.data[GAIN_W-1:0];
				else if (cfg.index == REG_CHANNELS_USED) cused <= cfg.data[CUSED_W-1:0];
			end
			// Accepted requests.
			if (pixel.valid && pixel.ready) begin
				if (pixel.func == FUNC_TABLE) begin
					if (pixel.table_index < TAB_DEPTH)
						wtab[pixel.table_index] = pixel.table_value;
				end else begin
					if (loaded < WIN) begin
						colors[loaded] = {pixel.color_2, pixel.color_1, pixel.color_0};
						sigs[loaded] = pixel.signal_in;
						loaded++;
					end
					if (pixel.last_pixel) filter_window();
				end
			end
			// Accepted results.
			if (result.valid && result.ready) begin
				if (awaited.size() == 0) begin
					$error("filtered_out unexpected, actual %h", result.filtered_out);
					errs++;
				end else begin
					e = awaited.pop_front();
					if (result.filtered_out !== e.value) begin
						$error("filtered_out expected %h actual %h", e.value,
							result.filtered_out);
						errs++;
					end
					if (result.last_out !== e.last) begin
						$error("last_out expected %b actual %b", e.last, result.last_out);
						errs++;
					end
				end
			end
			if (errs != 0) fail_count <= fail_count + errs;
		end
	end
endmodule

`default_nettype wire

[dv/tb_top.sv]
`default_nettype none

module tb_top;
	import rbwf_pkg::*;
	import rbwf_tb_pkg::*;

	logic clk;
	logic arst_n;
	int   fails;
	int   pending;
	int   quiet;
	bit   stall_mode;

	rbwf_pixel_if  pixel ();
	rbwf_result_if result ();
	rbwf_cfg_if    cfg ();

	recursive_bilateral_window_filter u_dut (
		.clk(clk), .arst_n(arst_n), .pixel(pixel), .result(result), .cfg(cfg));

	rbwf_checker u_chk (
		.clk(clk), .arst_n(arst_n), .pixel(pixel), .result(result), .cfg(cfg),
		.fail_count(fails), .pending(pending));

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Random stalls on the result side.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) result.ready <= 1'b0;
		else if (stall_mode) result.ready <= (gap_len() == 0);
		else result.ready <= 1'b1;
	end

	// Watchdog on accepted traffic.
	always @(posedge clk) begin
		if (!arst_n || (pixel.valid && pixel.ready) || (result.valid && result.ready)
				|| (cfg.valid && cfg.ready)) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet > 20000) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic idle_cycles(int n);
		repeat (n) @(posedge clk);
	endtask

	// A request holds valid across a zero-length gap so the next one follows directly.
	task automatic send(logic f, logic [9:0] ti, logic [16:0] tv, logic [23:0] col,
			logic [31:0] s, logic lst);
		int g;
		pixel.valid <= 1'b1;
		pixel.func <= f;
		pixel.table_index <= ti;
		pixel.table_value <= tv;
		{pixel.color_2, pixel.color_1, pixel.color_0} <= col;
		pixel.signal_in <= s;
		pixel.last_pixel <= lst;
		do @(posedge clk); while (!pixel.ready);
		g = gap_len();
		if (g != 0) begin
			pixel.valid <= 1'b0;
			idle_cycles(g);
		end
	endtask

	task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CDATA_W-1:0] d);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= d;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Stop sending and wait until every expected result has come.
	task automatic drain();
		pixel.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		idle_cycles(20);
	endtask

	// Write the table entries that the stimulus can reach: small distances and the
	// multiples of 255 from black and white windows.
	task automatic fill_table(bit random_vals);
		int d;
		for (int n = 0; n < 25; n++) begin
			d = (n < 22) ? n : (n - 21) * 255;
			send(FUNC_TABLE, 10'(d),
				random_vals ? 17'($urandom_range(0, 70000)) : 17'(65536 - d * 80),
				24'($urandom), 32'($urandom), 1'($urandom));
		end
	endtask

	// One full window; mode picks the flavor of its contents.
	task automatic send_window(int mode);
		logic [23:0] base, col;
		logic [31:0] s;
		base = 24'($urandom);
		for (int i = 0; i < WIN; i++) begin
			case (mode)
				0: col = {5'd0, 3'($urandom), 5'd0, 3'($urandom), 5'd0, 3'($urandom)};
				1: col = base ^ 24'($urandom_range(0, 7) * 24'h010101);
				2: col = (i / SIDE < 3) ? 24'h000000 : 24'hFFFFFF;
				default: col = base;
			endcase
			case (mode)
				2: s = (i % 2) ? 32'hFFFF_FFFF : 32'h0;
				3: s = 32'hFFFF_FFFF;
				default: s = $urandom;
			endcase
			send(FUNC_PIXEL, 10'($urandom), 17'($urandom), col, s, i == WIN - 1);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		stall_mode = 1'b0;
		pixel.valid = 1'b0;
		pixel.func = FUNC_TABLE;
		pixel.table_index = '0;
		pixel.table_value = '0;
		pixel.color_0 = '0;
		pixel.color_1 = '0;
		pixel.color_2 = '0;
		pixel.signal_in = '0;
		pixel.last_pixel = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = REG_SPREAD_GAIN;
		cfg.data = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Every reachable table entry is written first.
		fill_table(1'b0);
		// Table writes past the end, and a value above one.
		send(FUNC_TABLE, 10'd1023, 17'h1FFFF, 24'hFFFFFF, 32'hFFFF_FFFF, 1'b1);
		send(FUNC_TABLE, 10'd769, 17'd0, 24'h0, 32'h0, 1'b0);
		send(FUNC_TABLE, 10'd0, 17'h1FFFF, 24'h0, 32'h0, 1'b0);

		// Saturating window at reset settings.
		send_window(3);
		drain();

		// Extremes of gain and channel count, including out-of-range values.
		write_reg(REG_SPREAD_GAIN, 17'h1FFFF);
		write_reg(REG_CHANNELS_USED, 17'd0);
		send_window(2);
		drain();

		// Overfull window with random settings and result stalls: the last flag
		// rides on a pixel past the end.
		stall_mode = 1'b1;
		write_reg(REG_SPREAD_GAIN, 17'($urandom_range(0, 70000)));
		write_reg(REG_CHANNELS_USED, 17'($urandom_range(0, 3)));
		for (int i = 0; i < WIN; i++)
			send(FUNC_PIXEL, '0, '0,
				{5'd0, 3'($urandom), 5'd0, 3'($urandom), 5'd0, 3'($urandom)},
				$urandom, 1'b0);
		send(FUNC_PIXEL, '0, '0, 24'hFFFFFF, 32'hFFFF_FFFF, 1'b1);
		drain();

		if (fails == 0) $display("All tests passed");
		else $display("Some tests failed");
		$finish;
	end
endmodule

`default_nettype wire
